// ===== hw/rtl/tlpq_pkg.sv =====
// Shared types and constants of the three-level priority queue.
package tlpq_pkg;

   // Field widths fixed by the request and response formats.
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned LEVEL_W   = 2;
   localparam int unsigned OCC_W     = 5;

   // Request mode codes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // Highest priority level that an insert may carry.
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 2'd2;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_LEVEL = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // apply the captured request to the queue
   } ctrl_cmd_type;

endpackage

// ===== hw/rtl/tlpq_ctrl.sv =====
// Controller state machine of the three-level priority queue.
module tlpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output tlpq_pkg::ctrl_cmd_type cmd
);
   import tlpq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           strobe_ff, strobe_in;

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// ===== hw/rtl/tlpq_datapath.sv =====
// Datapath of the three-level priority queue: sorted cell row, count and result registers.
module tlpq_datapath #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tlpq_pkg::ctrl_cmd_type             cmd,
   input  logic                               req_mode,
   input  logic [tlpq_pkg::PAYLOAD_W-1:0]     req_payload,
   input  logic [tlpq_pkg::LEVEL_W-1:0]       req_level,
   output logic [1:0]                         rsp_status,
   output logic [tlpq_pkg::PAYLOAD_W-1:0]     rsp_out_payload,
   output logic [tlpq_pkg::LEVEL_W-1:0]       rsp_out_level,
   output logic [tlpq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import tlpq_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   // Cell 0 holds the head (highest level, oldest within it); the row grows upward.
   logic [PAYLOAD_W-1:0] cell_data_ff  [DEPTH];
   logic [PAYLOAD_W-1:0] cell_data_in  [DEPTH];
   logic [LEVEL_W-1:0]   cell_level_ff [DEPTH];
   logic [LEVEL_W-1:0]   cell_level_in [DEPTH];
   logic [CW-1:0]        count_ff, count_in;

   logic                 mode_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [LEVEL_W-1:0]   level_ff;

   logic [1:0]           status_ff;
   logic [PAYLOAD_W-1:0] out_payload_ff;
   logic [LEVEL_W-1:0]   out_level_ff;
   logic [OCC_W-1:0]     occupancy_ff;

   logic [DEPTH-1:0]     keep;
   logic                 is_full, is_empty;
   logic                 insert_ok, remove_ok;
   status_type           status_in;
   logic [CW+OCC_W-1:0]  occ_ext;

   // Request capture on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         payload_ff <= req_payload;
         level_ff   <= req_level;
      end
   end

   // A stored cell stays put on insert when its level is at least the new one.
   // Stored entries are sorted, so these flags form a prefix from cell 0.
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         keep[j] = (CW'(j) < count_ff) && (cell_level_ff[j] >= level_ff);
      end
   end

   // Operation decode and status.
   always_comb begin
      is_full   = (count_ff >= CW'(DEPTH));
      is_empty  = (count_ff == '0);
      insert_ok = 1'b0;
      remove_ok = 1'b0;
      status_in = STATUS_OK;
      if (mode_ff == MODE_INSERT) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else if (level_ff > LEVEL_MAX) begin
            status_in = STATUS_BAD_LEVEL;
         end else begin
            insert_ok = 1'b1;
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            remove_ok = 1'b1;
         end
      end
   end

   // Per-cell next value: hold, take the new item, or shift from a neighbour.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic take_new;
      logic [PAYLOAD_W-1:0] below_data;
      logic [LEVEL_W-1:0]   below_level;
      logic [PAYLOAD_W-1:0] above_data;
      logic [LEVEL_W-1:0]   above_level;

      if (g == 0) begin : g_first
         assign take_new    = ~keep[g];
         assign below_data  = cell_data_ff[g];
         assign below_level = cell_level_ff[g];
      end else begin : g_rest
         assign take_new    = ~keep[g] & keep[g-1];
         assign below_data  = cell_data_ff[g-1];
         assign below_level = cell_level_ff[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign above_data  = cell_data_ff[g];
         assign above_level = cell_level_ff[g];
      end else begin : g_inner
         assign above_data  = cell_data_ff[g+1];
         assign above_level = cell_level_ff[g+1];
      end

      always_comb begin
         cell_data_in[g]  = cell_data_ff[g];
         cell_level_in[g] = cell_level_ff[g];
         if (cmd.exec && insert_ok && !keep[g]) begin
            if (take_new) begin
               cell_data_in[g]  = payload_ff;
               cell_level_in[g] = level_ff;
            end else begin
               cell_data_in[g]  = below_data;
               cell_level_in[g] = below_level;
            end
         end else if (cmd.exec && remove_ok) begin
            cell_data_in[g]  = above_data;
            cell_level_in[g] = above_level;
         end
      end
   end

   // Cell row, no reset: only cells below the count are ever read.
   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         cell_data_ff[j]  <= cell_data_in[j];
         cell_level_ff[j] <= cell_level_in[j];
      end
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.exec && insert_ok) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.exec && remove_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Occupancy carries the low bits of the new count.
   assign occ_ext = {{OCC_W{1'b0}}, count_in};

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff      <= status_in;
         out_payload_ff <= remove_ok ? cell_data_ff[0] : '0;
         out_level_ff   <= remove_ok ? cell_level_ff[0] : '0;
         occupancy_ff   <= occ_ext[OCC_W-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_out_payload = out_payload_ff;
   assign rsp_out_level   = out_level_ff;
   assign rsp_occupancy   = occupancy_ff;

endmodule

// ===== hw/rtl/three_level_priority_queue_top.sv =====
// Top level of the three-level priority queue.
//
//   Channel   Handshake            Ports
//   request   start high, busy low req_mode, req_payload, req_level
//   response  rsp_strobe, 1 cycle  rsp_status, rsp_out_payload, rsp_out_level, rsp_occupancy
//
// A request is taken in one cycle and applied to the cell row in the next, while busy is high.
// The response follows in the next cycle on rsp_strobe, and a new request can be taken in that
// same cycle, so no new request is taken while one is still being applied; the request
// register in front of the compare-and-shift row sets that.
// Synchronous reset empties the queue at once; no clearing pass follows.
// The receiver cannot hold responses off: each one shows for exactly one cycle.
module three_level_priority_queue_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [tlpq_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [tlpq_pkg::LEVEL_W-1:0]   req_level,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [tlpq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   output logic [tlpq_pkg::LEVEL_W-1:0]   rsp_out_level,
   output logic [tlpq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import tlpq_pkg::*;

   ctrl_cmd_type cmd;

   // Sequencing of each request.
   tlpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Queue storage and result formation.
   tlpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_payload     (req_payload),
      .req_level       (req_level),
      .rsp_status      (rsp_status),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_level   (rsp_out_level),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

// ===== hw/rtl/tlpq_checker.sv =====
// Port-level checker of the three-level priority queue and its bind.
module tlpq_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic [1:0]                     rsp_status,
   input logic [tlpq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   input logic [tlpq_pkg::LEVEL_W-1:0]   rsp_out_level,
   input logic [tlpq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import tlpq_pkg::*;

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   // Every accepted request gets its response on rsp_strobe after the execute state.
   a_accept_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing after an accepted request");

   // A response never shows while a request is still being applied.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // Requests rejected as empty or for a bad level return no item.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK) && (rsp_status != STATUS_FULL))
         |-> (rsp_out_payload == '0 && rsp_out_level == '0))
      else $error("rejected request returned an item");

   // An empty queue reports zero occupancy.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_EMPTY)) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

endmodule

bind three_level_priority_queue_top tlpq_port_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_out_payload (rsp_out_payload),
   .rsp_out_level   (rsp_out_level),
   .rsp_occupancy   (rsp_occupancy)
);

// ===== tb/tlpq_checker.sv =====
// Checker that predicts and compares every response of the three-level priority queue.
`timescale 1ns / 100ps

module tlpq_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_mode,
   input  logic [tlpq_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [tlpq_pkg::LEVEL_W-1:0]   req_level,
   input  logic                           rsp_strobe,
   input  logic [1:0]                     rsp_status,
   input  logic [tlpq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   input  logic [tlpq_pkg::LEVEL_W-1:0]   rsp_out_level,
   input  logic [tlpq_pkg::OCC_W-1:0]     rsp_occupancy,
   output int unsigned                    outstanding,
   output int unsigned                    fail_count
);

   import tlpq_pkg::*;

   typedef struct {
      status_type             status;
      logic [PAYLOAD_W-1:0]   payload;
      logic [LEVEL_W-1:0]     level;
      logic [OCC_W-1:0]       occupancy;
   } queue_response_type;

   // Own copy of the sorted cell row, head at the top occupied index.
   logic [PAYLOAD_W-1:0] cell_data [DEPTH];
   logic [LEVEL_W-1:0]   cell_level [DEPTH];
   int unsigned          cell_count = 0;

   queue_response_type   awaited [$];
   int unsigned          errors = 0;

   // Apply one request to the predicted row and return the response it should give.
   function automatic queue_response_type queue_apply(logic mode, logic [PAYLOAD_W-1:0] payload,
                                                      logic [LEVEL_W-1:0] level);
      queue_response_type rsp;
      int unsigned        pos;
      rsp.status  = STATUS_OK;
      rsp.payload = '0;
      rsp.level   = '0;
      if (mode == MODE_INSERT) begin
         if (cell_count >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else if (level > LEVEL_MAX) begin
            rsp.status = STATUS_BAD_LEVEL;
         end else begin
            // The new entry goes just below the lowest cell at its level or above.
            pos = cell_count;
            for (int i = cell_count - 1; i >= 0; i--) begin
               if (cell_level[i] >= level) pos = i;
            end
            for (int i = cell_count; i > pos; i--) begin
               cell_data[i]  = cell_data[i-1];
               cell_level[i] = cell_level[i-1];
            end
            cell_data[pos]  = payload;
            cell_level[pos] = level;
            cell_count++;
         end
      end else begin
         if (cell_count == 0) begin
            rsp.status = STATUS_EMPTY;
         end else begin
            cell_count--;
            rsp.payload = cell_data[cell_count];
            rsp.level   = cell_level[cell_count];
         end
      end
      rsp.occupancy = cell_count[OCC_W-1:0];
      return rsp;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
         errors++;
      end
   endtask

   // Responses are checked before the request of the same edge is predicted, since a
   // response can never belong to a request taken at that very edge.
   always @(posedge clock) begin
      queue_response_type want;
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (awaited.size() == 0) begin
               $display("%0t: response with none expected, status %0d, payload 0x%08h",
                        $time, rsp_status, rsp_out_payload);
               errors++;
            end else begin
               want = awaited.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("out_payload", 32'(want.payload), 32'(rsp_out_payload));
               compare_field("out_level", 32'(want.level), 32'(rsp_out_level));
               compare_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            awaited.push_back(queue_apply(req_mode, req_payload, req_level));
         end
      end
      outstanding <= awaited.size();
      fail_count  <= errors;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top of the three-level priority queue: clock, reset, requests and verdict.
`timescale 1ns / 100ps

module tb;

   import tlpq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam logic [LEVEL_W-1:0] LEVEL_REJECT = LEVEL_MAX + 2'd1;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_mode = MODE_INSERT;
   logic [PAYLOAD_W-1:0] req_payload = '0;
   logic [LEVEL_W-1:0]   req_level = '0;
   logic                 rsp_strobe;
   logic [1:0]           rsp_status;
   logic [PAYLOAD_W-1:0] rsp_out_payload;
   logic [LEVEL_W-1:0]   rsp_out_level;
   logic [OCC_W-1:0]     rsp_occupancy;
   int unsigned          outstanding;
   int unsigned          fail_count;

   three_level_priority_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_payload(req_payload), .req_level(req_level),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_payload(rsp_out_payload),
      .rsp_out_level(rsp_out_level), .rsp_occupancy(rsp_occupancy)
   );

   tlpq_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_payload(req_payload), .req_level(req_level),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_payload(rsp_out_payload),
      .rsp_out_level(rsp_out_level), .rsp_occupancy(rsp_occupancy),
      .outstanding(outstanding), .fail_count(fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Present one request and hold it until the queue takes it.
   task automatic issue(logic mode, logic [PAYLOAD_W-1:0] payload, logic [LEVEL_W-1:0] level);
      start       <= 1'b1;
      req_mode    <= mode;
      req_payload <= payload;
      req_level   <= level;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every predicted response has been seen.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // A random request; inserts carry a rejected level now and then.
   task automatic random_request(int unsigned insert_pct);
      logic [LEVEL_W-1:0] level;
      level = ($urandom_range(99) < 8) ? LEVEL_REJECT : LEVEL_W'($urandom_range(LEVEL_MAX));
      if ($urandom_range(99) < insert_pct) issue(MODE_INSERT, $urandom, level);
      else issue(MODE_REMOVE, $urandom, LEVEL_W'($urandom));
   endtask

   initial begin
      int unsigned idle_pct [3];
      int unsigned insert_pct;
      idle_pct = '{0, 61, 7};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty and bad-level rejections, ordering across levels, a full queue.
      issue(MODE_REMOVE, 32'hFFFF_FFFF, LEVEL_REJECT);
      issue(MODE_INSERT, 32'h0000_0000, LEVEL_REJECT);
      issue(MODE_INSERT, 32'h0000_0000, 2'd2);
      issue(MODE_INSERT, 32'hFFFF_FFFF, 2'd0);
      issue(MODE_INSERT, 32'hA5A5_A5A5, 2'd1);
      issue(MODE_INSERT, 32'h5A5A_5A5A, 2'd2);
      issue(MODE_INSERT, 32'h0000_0001, 2'd1);
      issue(MODE_INSERT, 32'h8000_0000, 2'd0);
      issue(MODE_INSERT, 32'h7FFF_FFFF, 2'd2);
      issue(MODE_REMOVE, 32'h0000_0000, 2'd0);
      issue(MODE_REMOVE, 32'h1234_5678, 2'd1);
      for (int i = 0; i < 11; i++) issue(MODE_INSERT, $urandom, LEVEL_W'(i % 3));
      issue(MODE_INSERT, 32'h0000_0000, 2'd0);
      issue(MODE_INSERT, 32'hFFFF_FFFF, LEVEL_REJECT);
      drain();

      // Random part in phases of sender idling. The response side cannot stall, so only the
      // sender idles. The insert bias swings so the queue keeps running full and empty.
      foreach (idle_pct[p]) begin
         insert_pct = 50;
         for (int k = 0; k < 550; k++) begin
            if (k % 40 == 0) insert_pct = 15 + 35 * $urandom_range(2);
            if ($urandom_range(99) < idle_pct[p]) hold_off($urandom_range(1, 4));
            random_request(insert_pct);
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== three_level_priority_queue_top.f =====
hw/rtl/tlpq_pkg.sv
hw/rtl/tlpq_ctrl.sv
hw/rtl/tlpq_datapath.sv
hw/rtl/three_level_priority_queue_top.sv
hw/rtl/tlpq_checker.sv
tb/tlpq_checker.sv
tb/tb.sv
